>>> rtl/etf_pkg.sv
// shared types and constants of the escape-time fractal iterator
// no dependencies; used by every module of the block
package etf_pkg;

    localparam int FRAC_BITS_DEF   = 43;
    localparam int OFFSET_BITS_DEF = 12;
    localparam int CFG_W           = 48;
    localparam int STEP_W          = 47;
    localparam int STEP_LO_W       = 24;
    localparam int CNT_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [STEP_W-1:0] STEP_RST  = 47'd34359738368;
    localparam logic [CNT_W-1:0]  LIMIT_RST = 16'd128;
    localparam logic [CNT_W-1:0]  MIN_RST   = 16'd32768;
    localparam logic [CNT_W-1:0]  MAX_RST   = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_RE  = 3'd0,
        CFG_CENTER_IM  = 3'd1,
        CFG_PIXEL_STEP = 3'd2,
        CFG_JULIA_MODE = 3'd3,
        CFG_CONST_RE   = 3'd4,
        CFG_CONST_IM   = 3'd5,
        CFG_ITER_LIMIT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  center_re;
        logic [CFG_W-1:0]  center_im;
        logic [STEP_W-1:0] pixel_step;
        logic              julia_mode;
        logic [CFG_W-1:0]  const_re;
        logic [CFG_W-1:0]  const_im;
        logic [CNT_W-1:0]  iter_limit;
    } t_cfg;

endpackage

>>> rtl/etf_front.sv
// front end: accepts a pixel, maps it onto the complex plane, picks z0 and c
// depends on etf_pkg
module etf_front #(
    parameter int FRAC_BITS   = etf_pkg::FRAC_BITS_DEF,
    parameter int OFFSET_BITS = etf_pkg::OFFSET_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [OFFSET_BITS-1:0]     i_col_offset,
    input  logic [OFFSET_BITS-1:0]     i_row_offset,
    input  logic                       i_frame_start,
    input  etf_pkg::t_cfg              i_cfg,
    output logic                       o_q_push,
    output logic [4*(FRAC_BITS+5):0]   o_q_data,
    input  logic                       i_q_full
);
    localparam int CW   = FRAC_BITS + 5;
    localparam int LO_W = etf_pkg::STEP_LO_W;
    localparam int HI_W = etf_pkg::STEP_W - LO_W;
    localparam int PLW  = OFFSET_BITS + LO_W + 1;
    localparam int PHW  = OFFSET_BITS + HI_W + 1;
    localparam int SW   = 66;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        FS_IDLE = 4'b0001,
        FS_LO   = 4'b0010,
        FS_HI   = 4'b0100,
        FS_PUSH = 4'b1000
    } t_fstate;

    t_fstate                        r_state, n_state;
    logic signed [OFFSET_BITS-1:0]  r_col, r_row;
    logic                           r_start;
    logic signed [PLW-1:0]          r_plo_re, r_plo_im;
    logic signed [CW-1:0]           r_px, r_py;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[CW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] cfg_cw(input logic [etf_pkg::CFG_W-1:0] v);
        return sat_cw(SW'($signed(v)));
    endfunction

    logic signed [PHW-1:0] w_phi_re, w_phi_im;
    logic signed [SW-1:0]  w_sum_re, w_sum_im;
    logic signed [CW-1:0]  w_cen_re, w_cen_im, w_c_re, w_c_im;

    assign w_cen_re = cfg_cw(i_cfg.center_re);
    assign w_cen_im = cfg_cw(i_cfg.center_im);
    assign w_c_re   = cfg_cw(i_cfg.const_re);
    assign w_c_im   = cfg_cw(i_cfg.const_im);

    assign w_phi_re = r_col * $signed({1'b0, i_cfg.pixel_step[etf_pkg::STEP_W-1:LO_W]});
    assign w_phi_im = r_row * $signed({1'b0, i_cfg.pixel_step[etf_pkg::STEP_W-1:LO_W]});
    assign w_sum_re = (SW'(w_phi_re) <<< LO_W) + SW'(r_plo_re) + SW'(w_cen_re);
    assign w_sum_im = (SW'(w_phi_im) <<< LO_W) + SW'(r_plo_im) + SW'(w_cen_im);

    assign o_ready  = (r_state == FS_IDLE);
    assign o_q_push = (r_state == FS_PUSH) && !i_q_full;
    assign o_q_data = i_cfg.julia_mode ? {r_px, r_py, w_c_re, w_c_im, r_start}
                                       : {{(2*CW){1'b0}}, r_px, r_py, r_start};

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: if (i_valid) n_state = FS_LO;
            FS_LO:   n_state = FS_HI;
            FS_HI:   n_state = FS_PUSH;
            FS_PUSH: if (!i_q_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_valid) begin
            r_col   <= $signed(i_col_offset);
            r_row   <= $signed(i_row_offset);
            r_start <= i_frame_start;
        end
        if (r_state == FS_LO) begin
            r_plo_re <= r_col * $signed({1'b0, i_cfg.pixel_step[LO_W-1:0]});
            r_plo_im <= r_row * $signed({1'b0, i_cfg.pixel_step[LO_W-1:0]});
        end
        if (r_state == FS_HI) begin
            r_px <= sat_cw(w_sum_re);
            r_py <= sat_cw(w_sum_im);
        end
    end

endmodule

>>> rtl/etf_queue.sv
// short register queue between front and back end
// depends on etf_pkg for its default depth
module etf_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = etf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CNTW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/etf_mul.sv
// fixed-point multiplier: accumulates four half-width partial products in turn,
// then rounds toward zero and saturates; depends on etf_pkg
module etf_mul #(
    parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [FRAC_BITS+4:0] i_a,
    input  logic signed [FRAC_BITS+4:0] i_b,
    output logic                        o_done,
    output logic signed [FRAC_BITS+4:0] o_p
);
    localparam int CW = FRAC_BITS + 5;
    localparam int H  = (CW + 1) / 2;
    localparam int AW = 4 * H;
    localparam logic [AW-1:0] LIM = AW'(1) << (CW - 1);

    typedef enum logic [2:0] {
        MS_IDLE = 3'b001,
        MS_ACC  = 3'b010,
        MS_FIN  = 3'b100
    } t_mstate;

    t_mstate          r_state;
    logic [2*H-1:0]   r_ma, r_mb;
    logic             r_neg;
    logic [AW-1:0]    r_acc;
    logic [1:0]       r_k;
    logic             r_done;
    logic signed [CW-1:0] r_p;

    logic [H-1:0]   w_pa, w_pb;
    logic [2*H-1:0] w_part;
    logic [AW-1:0]  w_shift, w_m;
    logic [CW-1:0]  w_mag_a, w_mag_b;

    assign w_mag_a = i_a[CW-1] ? -i_a : i_a;
    assign w_mag_b = i_b[CW-1] ? -i_b : i_b;

    assign w_pa   = r_k[1] ? r_ma[2*H-1:H] : r_ma[H-1:0];
    assign w_pb   = r_k[0] ? r_mb[2*H-1:H] : r_mb[H-1:0];
    assign w_part = w_pa * w_pb;
    assign w_shift = (r_k == 2'd3) ? (AW'(w_part) << (2 * H)) :
                     (r_k == 2'd0) ? AW'(w_part) : (AW'(w_part) << H);
    assign w_m = r_acc >> FRAC_BITS;

    assign o_done = r_done;
    assign o_p    = r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MS_IDLE: if (i_start) r_state <= MS_ACC;
                MS_ACC:  if (r_k == 2'd3) r_state <= MS_FIN;
                MS_FIN: begin
                    r_state <= MS_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= MS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MS_IDLE: begin
                r_ma  <= (2*H)'(w_mag_a);
                r_mb  <= (2*H)'(w_mag_b);
                r_neg <= i_a[CW-1] ^ i_b[CW-1];
                r_acc <= '0;
                r_k   <= 2'd0;
            end
            MS_ACC: begin
                r_acc <= r_acc + w_shift;
                r_k   <= r_k + 2'd1;
            end
            MS_FIN: begin
                if (w_m >= LIM) begin
                    r_p <= r_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
                end else begin
                    r_p <= r_neg ? -$signed(w_m[CW-1:0]) : $signed(w_m[CW-1:0]);
                end
            end
            default: r_k <= 2'd0;
        endcase
    end

endmodule

>>> rtl/etf_back.sv
// back end: iterates z = z*z + c on three multipliers, tracks frame
// min and max and holds the result register; depends on etf_pkg, etf_mul
module etf_back #(
    parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [4*(FRAC_BITS+5):0]      i_q_data,
    output logic                          o_q_pop,
    input  logic [etf_pkg::CNT_W-1:0]     i_iter_limit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [etf_pkg::CNT_W-1:0]     o_iter_count,
    output logic [etf_pkg::CNT_W-1:0]     o_frame_min,
    output logic [etf_pkg::CNT_W-1:0]     o_frame_max
);
    localparam int CW = FRAC_BITS + 5;
    localparam int NW = etf_pkg::CNT_W;
    localparam logic signed [CW+1:0] SAT_HI = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [CW:0]   FOUR   = {6'b000100, {FRAC_BITS{1'b0}}};

    typedef enum logic [4:0] {
        BS_IDLE = 5'b00001,
        BS_MUL  = 5'b00010,
        BS_WAIT = 5'b00100,
        BS_CHK  = 5'b01000,
        BS_DONE = 5'b10000
    } t_bstate;

    t_bstate              r_state;
    logic signed [CW-1:0] r_zr, r_zi, r_cr, r_ci;
    logic                 r_start, r_esc;
    logic [NW-1:0]        r_n;
    logic                 r_out_valid;
    logic [NW-1:0]        r_out_n, r_min, r_max;

    logic                 w_mul_start, w_done_xx, w_done_yy, w_done_xy;
    logic signed [CW-1:0] w_xx, w_yy, w_xy;
    logic signed [CW:0]   w_mag2;
    logic signed [CW+1:0] w_re, w_im;
    logic                 w_out_free;
    logic [NW-1:0]        w_min, w_max;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [CW+1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[CW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    assign w_mul_start = (r_state == BS_MUL);

    etf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_a(r_zr), .i_b(r_zr), .o_done(w_done_xx), .o_p(w_xx)
    );
    etf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_yy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_a(r_zi), .i_b(r_zi), .o_done(w_done_yy), .o_p(w_yy)
    );
    etf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_a(r_zr), .i_b(r_zi), .o_done(w_done_xy), .o_p(w_xy)
    );

    assign w_mag2 = (CW+1)'(w_xx) + (CW+1)'(w_yy);
    assign w_re   = (CW+2)'(w_xx) - (CW+2)'(w_yy) + (CW+2)'(r_cr);
    assign w_im   = ((CW+2)'(w_xy) <<< 1) + (CW+2)'(r_ci);

    assign w_out_free = !r_out_valid || i_ready;
    assign w_min = (r_n < r_min) ? r_n : r_min;
    assign w_max = (r_n > r_max) ? r_n : r_max;

    assign o_q_pop      = (r_state == BS_IDLE) && i_q_valid;
    assign o_valid      = r_out_valid;
    assign o_iter_count = r_out_n;
    assign o_frame_min  = r_min;
    assign o_frame_max  = r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= etf_pkg::MIN_RST;
            r_max       <= etf_pkg::MAX_RST;
        end else begin
            case (r_state)
                BS_IDLE: if (i_q_valid) r_state <= BS_MUL;
                BS_MUL:  r_state <= BS_WAIT;
                BS_WAIT: if (w_done_xx && w_done_yy && w_done_xy) r_state <= BS_CHK;
                BS_CHK: begin
                    if (r_n >= i_iter_limit || r_esc) begin
                        r_state <= BS_DONE;
                    end else begin
                        r_state <= BS_MUL;
                    end
                end
                BS_DONE: begin
                    if (w_out_free) begin
                        r_state <= BS_IDLE;
                        r_min   <= r_start ? r_n : w_min;
                        r_max   <= r_start ? r_n : w_max;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase
            if (r_state == BS_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_zr    <= $signed(i_q_data[4*CW:3*CW+1]);
                r_zi    <= $signed(i_q_data[3*CW:2*CW+1]);
                r_cr    <= $signed(i_q_data[2*CW:CW+1]);
                r_ci    <= $signed(i_q_data[CW:1]);
                r_start <= i_q_data[0];
                r_n     <= '0;
                r_esc   <= 1'b0;
            end
            BS_WAIT: begin
                // the starting z is never tested
                r_esc <= (r_n != '0) && (w_mag2 >= FOUR);
            end
            BS_CHK: begin
                if (!(r_n >= i_iter_limit || r_esc)) begin
                    r_zr <= sat_cw(w_re);
                    r_zi <= sat_cw(w_im);
                    r_n  <= r_n + 1'b1;
                end
            end
            BS_DONE: begin
                if (w_out_free) begin
                    r_out_n <= r_n;
                end
            end
            default: r_esc <= r_esc;
        endcase
    end

endmodule

>>> rtl/escape_time_fractal_iterator_core.sv
// escape-time fractal iterator (mandelbrot / julia), fixed point
// path: the front end (states LO, HI, PUSH) and the queue, then one multiplier pass per iteration
// plus one for the squares of the starting z, and a retire state that waits for the output to be free
// throughput: the back end works on one pixel at a time, taking the next only after retiring the last
// reset: synchronous active low; registers take their defaults, min/max restart
module escape_time_fractal_iterator_core #(
    parameter int FRAC_BITS   = etf_pkg::FRAC_BITS_DEF,
    parameter int OFFSET_BITS = etf_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [OFFSET_BITS-1:0]            i_col_offset,
    input  logic [OFFSET_BITS-1:0]            i_row_offset,
    input  logic                              i_frame_start,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [etf_pkg::CNT_W-1:0]         o_iter_count,
    output logic [etf_pkg::CNT_W-1:0]         o_frame_min,
    output logic [etf_pkg::CNT_W-1:0]         o_frame_max,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [etf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [etf_pkg::CFG_W-1:0]         i_cfg_data
);
    localparam int CW = FRAC_BITS + 5;
    localparam int EW = 4 * CW + 1;

    etf_pkg::t_cfg   r_cfg;
    logic            w_push, w_full, w_qvalid, w_pop;
    logic [EW-1:0]   w_qin, w_qout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_re  <= '0;
            r_cfg.center_im  <= '0;
            r_cfg.pixel_step <= etf_pkg::STEP_RST;
            r_cfg.julia_mode <= 1'b0;
            r_cfg.const_re   <= '0;
            r_cfg.const_im   <= '0;
            r_cfg.iter_limit <= etf_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (etf_pkg::t_cfg_idx'(i_cfg_index))
                etf_pkg::CFG_CENTER_RE:  r_cfg.center_re  <= i_cfg_data;
                etf_pkg::CFG_CENTER_IM:  r_cfg.center_im  <= i_cfg_data;
                etf_pkg::CFG_PIXEL_STEP: r_cfg.pixel_step <= i_cfg_data[etf_pkg::STEP_W-1:0];
                etf_pkg::CFG_JULIA_MODE: r_cfg.julia_mode <= i_cfg_data[0];
                etf_pkg::CFG_CONST_RE:   r_cfg.const_re   <= i_cfg_data;
                etf_pkg::CFG_CONST_IM:   r_cfg.const_im   <= i_cfg_data;
                etf_pkg::CFG_ITER_LIMIT: r_cfg.iter_limit <= i_cfg_data[etf_pkg::CNT_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    etf_front #(.FRAC_BITS(FRAC_BITS), .OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_col_offset(i_col_offset), .i_row_offset(i_row_offset),
        .i_frame_start(i_frame_start), .i_cfg(r_cfg),
        .o_q_push(w_push), .o_q_data(w_qin), .i_q_full(w_full)
    );

    etf_queue #(.WIDTH(EW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_qin), .o_full(w_full),
        .o_valid(w_qvalid), .o_data(w_qout), .i_pop(w_pop)
    );

    etf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_qvalid), .i_q_data(w_qout), .o_q_pop(w_pop),
        .i_iter_limit(r_cfg.iter_limit),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_iter_count(o_iter_count), .o_frame_min(o_frame_min),
        .o_frame_max(o_frame_max)
    );

`ifndef NO_ASSERTIONS
    // a delivered count always lies between the frame's min and max
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_min <= o_iter_count) && (o_iter_count <= o_frame_max))
        else $error("count outside frame min/max");

    // the front end is not ready in the cycle after taking a beat
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("front end took two beats back to back");

    // count never exceeds the iteration limit while the configuration is not being written
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_cfg_valid && !$past(i_cfg_valid)) |->
            (o_iter_count <= r_cfg.iter_limit || o_iter_count == '0))
        else $error("count above iteration limit");
`endif

endmodule
